// ----- sv/clws_pkg.sv -----
// Shared types, constants and lookup functions for the character LCD write sequencer.
package clws_pkg;

    localparam int MAX_DIGITS_DEF   = 16;
    localparam int LINE_COLUMNS_DEF = 40;

    localparam logic [7:0] LCD_FUNC_SET    = 8'h38;
    localparam logic [7:0] LCD_DISP_ON     = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
    localparam logic [6:0] LCD_LINE2_BASE  = 7'h40;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_HEX_ALPHA  = 8'h37;
    localparam logic [31:0] RECIP_TEN      = 32'd52429;

    typedef enum logic [2:0] {
        CMD_INIT    = 3'd0,
        CMD_CHAR_AT = 3'd1,
        CMD_APPEND  = 3'd2,
        CMD_UDEC    = 3'd3,
        CMD_SDEC    = 3'd4,
        CMD_HEX     = 3'd5,
        CMD_BIN     = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CURSOR,
        ST_SIGN,
        ST_CHAR,
        ST_DIGITS,
        ST_INIT
    } state_t;

    typedef enum logic [2:0] {
        SEL_CURSOR,
        SEL_SIGN,
        SEL_CHAR,
        SEL_DIGIT,
        SEL_INIT
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv_step;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      pop;
        logic      init_adv;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       conv_zero;
        logic       emit_zero;
        logic       emit_one;
        logic       init_last;
        logic       out_free;
    } status_t;

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = LCD_FUNC_SET;
            2'd1:    b = LCD_DISP_ON;
            2'd2:    b = LCD_ENTRY_MODE;
            default: b = LCD_CLEAR;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            c = CHAR_HEX_ALPHA + {4'd0, d};
        end
        return c;
    endfunction

endpackage

// ----- sv/clws_req_if.sv -----
// Request channel: one display request per transfer.
interface clws_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [1:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
    logic [4:0]  digit_count;

    modport source (output valid, cmd, row, col, value, digit_count, input ready);
    modport sink   (input valid, cmd, row, col, value, digit_count, output ready);
endinterface

// ----- sv/clws_wr_if.sv -----
// Bus write channel: one LCD register write per transfer.
interface clws_wr_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, is_data, bus_byte, last, input ready);
    modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

// ----- sv/clws_ctrl.sv -----
// Sequencer state machine: orders conversion and bus writes for one request.
module clws_ctrl
    import clws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic [2:0] req_cmd,
    input  status_t st,
    output ctrl_t   ctl,
    output logic    idle
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_cmd)
                        CMD_INIT:    state_next = ST_INIT;
                        CMD_CHAR_AT: state_next = ST_CURSOR;
                        CMD_APPEND:  state_next = ST_CHAR;
                        CMD_UDEC, CMD_SDEC, CMD_HEX, CMD_BIN: state_next = ST_CONV;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (st.conv_zero)
                begin
                    state_next = ST_CURSOR;
                end
            end
            ST_CURSOR:
            begin
                if (st.out_free)
                begin
                    case (st.cmd)
                        CMD_CHAR_AT: state_next = ST_CHAR;
                        CMD_SDEC:    state_next = ST_SIGN;
                        default:     state_next = st.emit_zero ? ST_IDLE : ST_DIGITS;
                    endcase
                end
            end
            ST_SIGN:
            begin
                if (st.out_free)
                begin
                    state_next = st.emit_zero ? ST_IDLE : ST_DIGITS;
                end
            end
            ST_CHAR:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIGITS:
            begin
                if (st.out_free && st.emit_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                if (st.out_free && st.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl  = '0;
        ctl.sel = SEL_CURSOR;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle     = 1'b1;
                ctl.load = req_valid;
            end
            ST_CONV:
            begin
                ctl.conv_step = !st.conv_zero;
            end
            ST_CURSOR:
            begin
                ctl.emit = st.out_free;
                ctl.sel  = SEL_CURSOR;
                ctl.last = (st.cmd != CMD_CHAR_AT) && (st.cmd != CMD_SDEC) && st.emit_zero;
            end
            ST_SIGN:
            begin
                ctl.emit = st.out_free;
                ctl.sel  = SEL_SIGN;
                ctl.last = st.emit_zero;
            end
            ST_CHAR:
            begin
                ctl.emit = st.out_free;
                ctl.sel  = SEL_CHAR;
                ctl.last = 1'b1;
            end
            ST_DIGITS:
            begin
                ctl.emit = st.out_free;
                ctl.pop  = st.out_free;
                ctl.sel  = SEL_DIGIT;
                ctl.last = st.emit_one;
            end
            ST_INIT:
            begin
                ctl.emit     = st.out_free;
                ctl.init_adv = st.out_free;
                ctl.sel      = SEL_INIT;
                ctl.last     = st.init_last;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/clws_dpath.sv -----
// Datapath: request capture, digit conversion, digit stack and output register.
module clws_dpath
    import clws_pkg::*;
#(
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctl,
    output status_t     st,
    input  logic [2:0]  req_cmd,
    input  logic [1:0]  req_row,
    input  logic [5:0]  req_col,
    input  logic [15:0] req_value,
    input  logic [4:0]  req_digit_count,
    output logic        wr_valid,
    input  logic        wr_ready,
    output logic        wr_is_data,
    output logic [7:0]  wr_bus_byte,
    output logic        wr_last
);

    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [2:0]  cmd_reg;
    logic [7:0]  cursor_reg;
    logic [7:0]  char_reg;
    logic [7:0]  sign_reg;
    logic [15:0] val_reg,  val_next;
    logic [CW-1:0] conv_left_reg, conv_left_next;
    logic [CW-1:0] emit_left_reg, emit_left_next;
    logic [1:0]  init_idx_reg, init_idx_next;
    logic [3:0]  stack_reg  [MAX_DIGITS];
    logic [3:0]  stack_next [MAX_DIGITS];
    logic        out_valid_reg, out_valid_next;
    logic        out_is_data_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic [CW-1:0] cnt_in;
    logic [5:0]    col_clamped;
    logic [6:0]    ddram_addr;
    logic [15:0]   mag_in;
    logic [31:0]   prod;
    logic [12:0]   quot10;
    logic [15:0]   quot10_x10;
    logic [15:0]   dec_rem;
    logic [3:0]    digit;
    logic [15:0]   val_shifted;
    logic [7:0]    emit_byte;

    // clamp digit count and column
    always_comb
    begin
        if (req_digit_count > 5'(MAX_DIGITS))
        begin
            cnt_in = CW'(MAX_DIGITS);
        end
        else
        begin
            cnt_in = CW'(req_digit_count);
        end

        if (req_col == 6'd0)
        begin
            col_clamped = 6'd1;
        end
        else if (req_col > 6'(LINE_COLUMNS))
        begin
            col_clamped = 6'(LINE_COLUMNS);
        end
        else
        begin
            col_clamped = req_col;
        end

        ddram_addr = {1'b0, col_clamped - 6'd1} + ((req_row != 2'd1) ? LCD_LINE2_BASE : 7'd0);
        mag_in     = (req_cmd == CMD_SDEC && req_value[15]) ? (~req_value + 16'd1) : req_value;
    end

    // one digit per step: divide by ten via reciprocal, or shift for hex and binary
    always_comb
    begin
        prod       = {16'd0, val_reg} * RECIP_TEN;
        quot10     = prod[31:19];
        quot10_x10 = {quot10, 3'b000} + {2'b00, quot10, 1'b0};
        dec_rem    = val_reg - quot10_x10;
        case (cmd_reg)
            CMD_HEX:
            begin
                digit       = val_reg[3:0];
                val_shifted = {4'd0, val_reg[15:4]};
            end
            CMD_BIN:
            begin
                digit       = {3'd0, val_reg[0]};
                val_shifted = {1'b0, val_reg[15:1]};
            end
            default:
            begin
                digit       = dec_rem[3:0];
                val_shifted = {3'd0, quot10};
            end
        endcase
    end

    always_comb
    begin
        val_next       = val_reg;
        conv_left_next = conv_left_reg;
        emit_left_next = emit_left_reg;
        init_idx_next  = init_idx_reg;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            stack_next[i] = stack_reg[i];
        end

        if (ctl.load)
        begin
            val_next       = mag_in;
            conv_left_next = cnt_in;
            emit_left_next = cnt_in;
            init_idx_next  = 2'd0;
        end
        if (ctl.conv_step)
        begin
            val_next       = val_shifted;
            conv_left_next = conv_left_reg - CW'(1);
            stack_next[0]  = digit;
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
        end
        if (ctl.pop)
        begin
            emit_left_next = emit_left_reg - CW'(1);
            for (int i = 0; i < MAX_DIGITS - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
            stack_next[MAX_DIGITS-1] = 4'd0;
        end
        if (ctl.init_adv)
        begin
            init_idx_next = init_idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        case (ctl.sel)
            SEL_CURSOR: emit_byte = cursor_reg;
            SEL_SIGN:   emit_byte = sign_reg;
            SEL_CHAR:   emit_byte = char_reg;
            SEL_DIGIT:  emit_byte = digit_ascii(stack_reg[0]);
            SEL_INIT:   emit_byte = init_byte(init_idx_reg);
            default:    emit_byte = 8'd0;
        endcase

        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (wr_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_left_reg <= '0;
            emit_left_reg <= '0;
            init_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            conv_left_reg <= conv_left_next;
            emit_left_reg <= emit_left_next;
            init_idx_reg  <= init_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= req_cmd;
            cursor_reg <= LCD_SET_DDRAM | {1'b0, ddram_addr};
            char_reg   <= req_value[7:0];
            sign_reg   <= req_value[15] ? CHAR_MINUS : CHAR_PLUS;
        end
        val_reg <= val_next;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            stack_reg[i] <= stack_next[i];
        end
        if (ctl.emit)
        begin
            out_is_data_reg <= (ctl.sel != SEL_CURSOR) && (ctl.sel != SEL_INIT);
            out_byte_reg    <= emit_byte;
            out_last_reg    <= ctl.last;
        end
    end

    assign st.cmd       = cmd_reg;
    assign st.conv_zero = (conv_left_reg == '0);
    assign st.emit_zero = (emit_left_reg == '0);
    assign st.emit_one  = (emit_left_reg == CW'(1));
    assign st.init_last = (init_idx_reg == 2'd3);
    assign st.out_free  = !out_valid_reg || wr_ready;

    assign wr_valid    = out_valid_reg;
    assign wr_is_data  = out_is_data_reg;
    assign wr_bus_byte = out_byte_reg;
    assign wr_last     = out_last_reg;

endmodule

// ----- sv/char_lcd_write_sequencer_unit.sv -----
// Top level of the character LCD write sequencer: controller, datapath and checks.
//
//  channel | dir | transfer                       | payload
//  --------+-----+--------------------------------+----------------------------------
//  req     | in  | one display request            | cmd, row, col, value, digit_count
//  wr      | out | one LCD register write         | is_data, bus_byte, last
//
// A request is taken only when the sequencer is idle. Numeric requests first
// run the digit loop, one digit per cycle (divide by ten through a reciprocal
// multiply, or a shift for hex and binary), then emit one write per cycle.
// A signed request adds a sign write after the cursor; init writes four
// commands, char-at-position a cursor and a character, append one character.
// The single output register sets the write rate: a stall on wr holds the
// sequence where it stands.
// The next request is taken while its predecessor's last write still waits.
// Reset clears the state machine, counters and the output valid flag.
module char_lcd_write_sequencer_unit
    import clws_pkg::*;
#(
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int LINE_COLUMNS = LINE_COLUMNS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    clws_req_if.sink  req,
    clws_wr_if.source wr
);

    ctrl_t   ctl;
    status_t st;
    logic    idle;

    // controller sees the request handshake and command; everything else is status
    clws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .st        (st),
        .ctl       (ctl),
        .idle      (idle)
    );

    clws_dpath #(
        .MAX_DIGITS   (MAX_DIGITS),
        .LINE_COLUMNS (LINE_COLUMNS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .st              (st),
        .req_cmd         (req.cmd),
        .req_row         (req.row),
        .req_col         (req.col),
        .req_value       (req.value),
        .req_digit_count (req.digit_count),
        .wr_valid        (wr.valid),
        .wr_ready        (wr.ready),
        .wr_is_data      (wr.is_data),
        .wr_bus_byte     (wr.bus_byte),
        .wr_last         (wr.last)
    );

    // accept a request only while idle
    assign req.ready = idle;

    // the final write of a request returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit && ctl.last |=> req.ready)
        else $error("sequencer not idle after final write");

    // digits pop only after conversion finished and while some remain
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (st.conv_zero && !st.emit_zero))
        else $error("digit pop out of order");

    // conversion steps only while digits remain, no request is taken and no write is emitted
    a_conv_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.conv_step |-> (!st.conv_zero && !req.ready && !ctl.emit))
        else $error("conversion step out of order");

endmodule
